[rtl/sfbr_pkg.sv]
// Package for the stereo field bin rotator: constants, CORDIC arctangent table,
// configuration register indexes and mode codes. No dependencies.
package sfbr_pkg;

   localparam int SAMPLE_BITS_DEF   = 24;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int TAB_LEN           = 24;

   // Angles: pi = 2^31, held in 34-bit signed words.
   localparam int ANG_W = 34;
   localparam logic signed [ANG_W-1:0] ANG_PI      = 34'sd2147483648;
   localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 34'sd1073741824;
   localparam logic signed [33:0]      KINV_Q30    = 34'sd652032874;

   typedef enum logic [2:0] {
      REG_MODE  = 3'd0,
      REG_DEPTH = 3'd1,
      REG_GIN   = 3'd2,
      REG_GOUT  = 3'd3,
      REG_PAN   = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_LEFT   = 2'd0,
      MODE_RIGHT  = 2'd1,
      MODE_STEREO = 2'd2,
      MODE_BYPASS = 2'd3
   } mode_type;

   function automatic logic signed [ANG_W-1:0] atan_tab(input int i);
      logic signed [ANG_W-1:0] r;
      case (i)
         0: r = 34'sd536870912;   1: r = 34'sd316933406;   2: r = 34'sd167458907;
         3: r = 34'sd85004756;    4: r = 34'sd42667331;    5: r = 34'sd21354465;
         6: r = 34'sd10679838;    7: r = 34'sd5340245;     8: r = 34'sd2670163;
         9: r = 34'sd1335087;     10: r = 34'sd667544;     11: r = 34'sd333772;
         12: r = 34'sd166886;     13: r = 34'sd83443;      14: r = 34'sd41722;
         15: r = 34'sd20861;      16: r = 34'sd10430;      17: r = 34'sd5215;
         18: r = 34'sd2608;       19: r = 34'sd1304;       20: r = 34'sd652;
         21: r = 34'sd326;        22: r = 34'sd163;        23: r = 34'sd81;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

[rtl/stereo_field_bin_rotator_top.sv]
// Stereo field bin rotator: cross-spectrum phase by CORDIC vectoring, bin
// rotation by CORDIC, gain blend, pan and saturation. Uses sfbr_pkg.
// Throughput: one bin per cycle; every CORDIC iteration is a pipeline stage.
// The whole pipeline advances together and holds when the output stalls.
// Reset (synchronous, active high) clears valid bits and loads register defaults.
module stereo_field_bin_rotator_top #(
   parameter int SAMPLE_BITS   = sfbr_pkg::SAMPLE_BITS_DEF,
   parameter int CORDIC_STAGES = sfbr_pkg::CORDIC_STAGES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // left_real, left_imag, right_real, right_imag from the lowest bit up
   input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   input  logic                       req_tlast,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // out_left_real, out_left_imag, out_right_real, out_right_imag, lowest bit up
   output logic [((4*SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic                       rsp_tlast,
   input  logic                       csr_we,
   input  logic [2:0]                 csr_index,
   input  logic [15:0]                csr_wdata
);
   localparam int SB   = SAMPLE_BITS;
   localparam int NS   = (CORDIC_STAGES < sfbr_pkg::TAB_LEN) ? CORDIC_STAGES
                                                             : sfbr_pkg::TAB_LEN;
   localparam int SH   = (2*SB > 61) ? 2*SB - 61 : 0;
   localparam int PW   = 2*SB - SH;          // product width after shift
   localparam int CW   = PW + 2;             // cross-spectrum width
   localparam int VW   = CW + NS + 2;        // vectoring x/y width
   localparam int AW   = sfbr_pkg::ANG_W;
   localparam int RW   = 34;                 // rotation c/s width
   localparam int XW   = SB + 2;             // rotated part width
   localparam int DW   = ((4*SB+7)/8)*8;
   // Stage count: 1 product, 1 cross, 1 pre, NS vector, 1 phase, 1 angle,
   // 1 pre-rot, NS rot, 1 flip, 1 rot mult, 1 rot sum, 1 gain, 1 pan.
   localparam int NST  = 2*NS + 11;

   // ---------------- configuration ----------------
   logic [1:0]         mode_ff;
   logic signed [15:0] depth_ff, pan_ff;
   logic [15:0]        gin_ff, gout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= sfbr_pkg::MODE_STEREO;
         depth_ff <= '0;
         gin_ff   <= 16'd16384;
         gout_ff  <= 16'd16384;
         pan_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            sfbr_pkg::REG_MODE:  mode_ff  <= csr_wdata[1:0];
            sfbr_pkg::REG_DEPTH: depth_ff <= csr_wdata;
            sfbr_pkg::REG_GIN:   gin_ff   <= csr_wdata;
            sfbr_pkg::REG_GOUT:  gout_ff  <= csr_wdata;
            sfbr_pkg::REG_PAN:   pan_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic advance;
   logic [NST-1:0] vld_ff;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = vld_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[NST-2:0], req_tvalid};
   end

   // Items carry their inputs and last flag along the whole pipe.
   typedef struct packed {
      logic signed [SB-1:0] lr, li, rr, ri;
      logic                 last;
   } bin_type;

   bin_type bin_ff [NST];
   bin_type bin_in;
   assign bin_in.lr   = req_tdata[SB-1:0];
   assign bin_in.li   = req_tdata[2*SB-1:SB];
   assign bin_in.rr   = req_tdata[3*SB-1:2*SB];
   assign bin_in.ri   = req_tdata[4*SB-1:3*SB];
   assign bin_in.last = req_tlast;

   always_ff @(posedge clock) begin
      if (advance) begin
         bin_ff[0] <= bin_in;
         for (int k = 1; k < NST; k++) bin_ff[k] <= bin_ff[k-1];
      end
   end

   // ---------------- stage 0: products ----------------
   logic signed [2*SB-1:0] p_lrrr_ff, p_liri_ff, p_lrri_ff, p_lirr_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         p_lrrr_ff <= bin_in.lr * bin_in.rr;
         p_liri_ff <= bin_in.li * bin_in.ri;
         p_lrri_ff <= bin_in.lr * bin_in.ri;
         p_lirr_ff <= bin_in.li * bin_in.rr;
      end
   end

   // ---------------- stage 1: cross spectrum ----------------
   logic signed [CW-1:0] cr_ff, ci_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         cr_ff <= CW'(p_lrrr_ff >>> SH) + CW'(p_liri_ff >>> SH);
         ci_ff <= CW'(p_lrri_ff >>> SH) - CW'(p_lirr_ff >>> SH);
      end
   end

   // ---------------- stage 2: quadrant pre-rotation ----------------
   logic signed [VW-1:0] vx_ff [NS+1];
   logic signed [VW-1:0] vy_ff [NS+1];
   logic signed [AW-1:0] vz_ff [NS+1];
   always_ff @(posedge clock) begin
      if (advance) begin
         if (cr_ff < 0) begin
            if (ci_ff >= 0) begin
               vx_ff[0] <= VW'(ci_ff);
               vy_ff[0] <= -VW'(cr_ff);
               vz_ff[0] <= sfbr_pkg::ANG_HALF_PI;
            end else begin
               vx_ff[0] <= -VW'(ci_ff);
               vy_ff[0] <= VW'(cr_ff);
               vz_ff[0] <= -sfbr_pkg::ANG_HALF_PI;
            end
         end else begin
            vx_ff[0] <= VW'(cr_ff);
            vy_ff[0] <= VW'(ci_ff);
            vz_ff[0] <= '0;
         end
      end
   end

   // ---------------- vectoring stages ----------------
   for (genvar i = 0; i < NS; i++) begin : g_vec
      always_ff @(posedge clock) begin
         if (advance) begin
            if (vy_ff[i] > 0) begin
               vx_ff[i+1] <= vx_ff[i] + (vy_ff[i] >>> i);
               vy_ff[i+1] <= vy_ff[i] - (vx_ff[i] >>> i);
               vz_ff[i+1] <= vz_ff[i] + sfbr_pkg::atan_tab(i);
            end else if (vy_ff[i] < 0) begin
               vx_ff[i+1] <= vx_ff[i] - (vy_ff[i] >>> i);
               vy_ff[i+1] <= vy_ff[i] + (vx_ff[i] >>> i);
               vz_ff[i+1] <= vz_ff[i] - sfbr_pkg::atan_tab(i);
            end else begin
               vx_ff[i+1] <= vx_ff[i];
               vy_ff[i+1] <= vy_ff[i];
               vz_ff[i+1] <= vz_ff[i];
            end
         end
      end
   end

   // ---------------- phase stage: clamp, halve, magnitude ----------------
   logic stereo;
   assign stereo = (mode_ff == sfbr_pkg::MODE_STEREO);
   logic signed [AW-1:0] zc, a_c, aa_c, w_c;
   always_comb begin
      zc = vz_ff[NS];
      if (zc > sfbr_pkg::ANG_PI) zc = sfbr_pkg::ANG_PI;
      if (zc < -sfbr_pkg::ANG_PI) zc = -sfbr_pkg::ANG_PI;
      a_c  = stereo ? (zc >>> 1) : zc;
      aa_c = (a_c < 0) ? -a_c : a_c;
      w_c  = stereo ? (aa_c <<< 1) : aa_c;
      if (w_c > sfbr_pkg::ANG_PI) w_c = sfbr_pkg::ANG_PI;
   end
   logic signed [AW-1:0] a_ff, aa_ff, w_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff  <= a_c;
         aa_ff <= aa_c;
         w_ff  <= w_c;
      end
   end

   // ---------------- angle stage: depth scaling and gain blend ----------------
   logic signed [16:0] m_c, s_c;
   logic signed [AW-1:0] pim_c;
   logic signed [AW+17:0] t_ma, t_spim, t_saa;
   logic signed [AW-1:0] r_ma, r_spim, r_saa;
   logic signed [31:0] thl_c, thr_c;
   always_comb begin
      m_c   = (depth_ff < 0) ? 17'(depth_ff) : '0;
      s_c   = (depth_ff > 0) ? 17'(depth_ff) : '0;
      pim_c = sfbr_pkg::ANG_PI - aa_ff;
      t_ma   = (AW+18)'(m_c) * (AW+18)'(a_ff) + (AW+18)'(16384);
      t_spim = (AW+18)'(s_c) * (AW+18)'(pim_c) + (AW+18)'(16384);
      t_saa  = (AW+18)'(s_c) * (AW+18)'(aa_ff) + (AW+18)'(16384);
      r_ma   = AW'(t_ma >>> 15);
      r_spim = AW'(t_spim >>> 15);
      r_saa  = AW'(t_saa >>> 15);
      // mul15(m,-a) = -mul15(m,a) rounded differently; compute exactly.
      t_ma   = (AW+18)'(m_c) * (AW+18)'(-a_ff) + (AW+18)'(16384);
      thl_c  = 32'(AW'(t_ma >>> 15) + r_spim);
      case (mode_ff)
         sfbr_pkg::MODE_RIGHT: thr_c = 32'(r_ma - r_spim);
         default:              thr_c = 32'(r_ma + r_saa);
      endcase
   end
   logic signed [31:0] thl_ff, thr_ff;
   logic [1:0]         mode_p_ff [NS+6];
   logic signed [16:0] bx_ff;
   logic [AW+17:0]     gsum;
   always_comb begin
      gsum = (AW+18)'(gout_ff) * (AW+18)'(w_ff)
           + (AW+18)'(gin_ff) * (AW+18)'(sfbr_pkg::ANG_PI - w_ff) + (AW+18)'(1 << 30);
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         thl_ff       <= thl_c;
         thr_ff       <= thr_c;
         bx_ff        <= 17'(gsum >> 31);
         mode_p_ff[0] <= mode_ff;
         for (int k = 1; k < NS+6; k++) mode_p_ff[k] <= mode_p_ff[k-1];
      end
   end
   logic signed [16:0] bx_p_ff [NS+4];
   always_ff @(posedge clock) begin
      if (advance) begin
         bx_p_ff[0] <= bx_ff;
         for (int k = 1; k < NS+4; k++) bx_p_ff[k] <= bx_p_ff[k-1];
      end
   end

   // ---------------- rotation CORDIC, left and right lanes ----------------
   logic signed [RW-1:0] lc_ff [NS+1], ls_ff [NS+1], rc_ff [NS+1], rs_ff [NS+1];
   logic signed [AW-1:0] lz_ff [NS+1], rz_ff [NS+1];
   logic [NS:0]          lf_ff, rf_ff;

   function automatic logic signed [AW-1:0] fold(input logic signed [31:0] th,
                                                 output logic flip);
      logic signed [AW-1:0] z;
      z    = AW'(th);
      flip = 1'b0;
      if (z > sfbr_pkg::ANG_HALF_PI) begin
         z = z - sfbr_pkg::ANG_PI; flip = 1'b1;
      end else if (z < -sfbr_pkg::ANG_HALF_PI) begin
         z = z + sfbr_pkg::ANG_PI; flip = 1'b1;
      end
      return z;
   endfunction

   logic signed [AW-1:0] lz0, rz0;
   logic lfl, rfl;
   always_comb begin
      lz0 = fold(thl_ff, lfl);
      rz0 = fold(thr_ff, rfl);
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         lc_ff[0] <= sfbr_pkg::KINV_Q30; ls_ff[0] <= '0; lz_ff[0] <= lz0; lf_ff[0] <= lfl;
         rc_ff[0] <= sfbr_pkg::KINV_Q30; rs_ff[0] <= '0; rz_ff[0] <= rz0; rf_ff[0] <= rfl;
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_rot
      always_ff @(posedge clock) begin
         if (advance) begin
            lf_ff[i+1] <= lf_ff[i];
            rf_ff[i+1] <= rf_ff[i];
            if (lz_ff[i] >= 0) begin
               lc_ff[i+1] <= lc_ff[i] - (ls_ff[i] >>> i);
               ls_ff[i+1] <= ls_ff[i] + (lc_ff[i] >>> i);
               lz_ff[i+1] <= lz_ff[i] - sfbr_pkg::atan_tab(i);
            end else begin
               lc_ff[i+1] <= lc_ff[i] + (ls_ff[i] >>> i);
               ls_ff[i+1] <= ls_ff[i] - (lc_ff[i] >>> i);
               lz_ff[i+1] <= lz_ff[i] + sfbr_pkg::atan_tab(i);
            end
            if (rz_ff[i] >= 0) begin
               rc_ff[i+1] <= rc_ff[i] - (rs_ff[i] >>> i);
               rs_ff[i+1] <= rs_ff[i] + (rc_ff[i] >>> i);
               rz_ff[i+1] <= rz_ff[i] - sfbr_pkg::atan_tab(i);
            end else begin
               rc_ff[i+1] <= rc_ff[i] + (rs_ff[i] >>> i);
               rs_ff[i+1] <= rs_ff[i] - (rc_ff[i] >>> i);
               rz_ff[i+1] <= rz_ff[i] + sfbr_pkg::atan_tab(i);
            end
         end
      end
   end

   // flip stage
   logic signed [RW-1:0] lc2_ff, ls2_ff, rc2_ff, rs2_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         lc2_ff <= lf_ff[NS] ? -lc_ff[NS] : lc_ff[NS];
         ls2_ff <= lf_ff[NS] ? -ls_ff[NS] : ls_ff[NS];
         rc2_ff <= rf_ff[NS] ? -rc_ff[NS] : rc_ff[NS];
         rs2_ff <= rf_ff[NS] ? -rs_ff[NS] : rs_ff[NS];
      end
   end

   // rotation multiply stage; bin_ff index of this stage's input
   localparam int BR = 2*NS + 6;
   localparam int MW = SB + RW;
   logic signed [MW-1:0] lrc_ff, lis_ff, lrs_ff, lic_ff, rrc_ff, ris_ff, rrs_ff, ric_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         lrc_ff <= MW'(bin_ff[BR].lr) * MW'(lc2_ff);
         lis_ff <= MW'(bin_ff[BR].li) * MW'(ls2_ff);
         lrs_ff <= MW'(bin_ff[BR].lr) * MW'(ls2_ff);
         lic_ff <= MW'(bin_ff[BR].li) * MW'(lc2_ff);
         rrc_ff <= MW'(bin_ff[BR].rr) * MW'(rc2_ff);
         ris_ff <= MW'(bin_ff[BR].ri) * MW'(rs2_ff);
         rrs_ff <= MW'(bin_ff[BR].rr) * MW'(rs2_ff);
         ric_ff <= MW'(bin_ff[BR].ri) * MW'(rc2_ff);
      end
   end

   // rotation sum stage, with unrotated side chosen by mode
   localparam logic signed [MW:0] HALF30 = (MW+1)'(1) <<< 29;
   logic signed [XW-1:0] xlr_ff, xli_ff, xrr_ff, xri_ff;
   logic [1:0] md_s;
   logic signed [MW:0] slr, sli, srr, sri;
   always_comb begin
      md_s = mode_p_ff[NS+3];
      slr = ((MW+1)'(lrc_ff) - (MW+1)'(lis_ff) + HALF30) >>> 30;
      sli = ((MW+1)'(lrs_ff) + (MW+1)'(lic_ff) + HALF30) >>> 30;
      srr = ((MW+1)'(rrc_ff) - (MW+1)'(ris_ff) + HALF30) >>> 30;
      sri = ((MW+1)'(rrs_ff) + (MW+1)'(ric_ff) + HALF30) >>> 30;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         if (md_s == sfbr_pkg::MODE_RIGHT) begin
            xlr_ff <= XW'(bin_ff[BR+1].lr); xli_ff <= XW'(bin_ff[BR+1].li);
         end else begin
            xlr_ff <= XW'(slr); xli_ff <= XW'(sli);
         end
         if (md_s == sfbr_pkg::MODE_LEFT) begin
            xrr_ff <= XW'(bin_ff[BR+1].rr); xri_ff <= XW'(bin_ff[BR+1].ri);
         end else begin
            xrr_ff <= XW'(srr); xri_ff <= XW'(sri);
         end
      end
   end

   // gain stage
   localparam int GW = XW + 18;
   logic signed [GW-1:0] glr_ff, gli_ff, grr_ff, gri_ff;
   logic signed [16:0] bxg;
   assign bxg = bx_p_ff[NS+3];
   function automatic logic signed [GW-1:0] gmul(input logic signed [XW-1:0] v,
                                                 input logic signed [16:0] g);
      logic signed [GW-1:0] t;
      t = GW'(v) * GW'(g) + GW'(8192);
      return t >>> 14;
   endfunction
   always_ff @(posedge clock) begin
      if (advance) begin
         glr_ff <= gmul(xlr_ff, bxg);
         gli_ff <= gmul(xli_ff, bxg);
         grr_ff <= gmul(xrr_ff, bxg);
         gri_ff <= gmul(xri_ff, bxg);
      end
   end

   // pan and saturation stage
   localparam int QW = GW + 18;
   logic signed [16:0] lx, rx;
   assign lx = (pan_ff > 0) ? 17'sd32768 - 17'(pan_ff) : 17'sd32768;
   assign rx = (pan_ff < 0) ? 17'sd32768 + 17'(pan_ff) : 17'sd32768;
   function automatic logic [SB-1:0] pfin(input logic signed [GW-1:0] v,
                                          input logic signed [16:0] pw);
      logic signed [QW-1:0] t;
      logic signed [QW-1:0] hi, lo;
      hi = (QW'(1) <<< (SB-1)) - QW'(1);
      lo = -hi - QW'(1);
      t = (QW'(v) * QW'(pw) + QW'(16384)) >>> 15;
      if (t > hi) t = hi;
      if (t < lo) t = lo;
      return t[SB-1:0];
   endfunction
   logic [SB-1:0] olr_ff, oli_ff, orr_ff, ori_ff;
   logic bypass;
   assign bypass = (mode_p_ff[NS+5] == sfbr_pkg::MODE_BYPASS);
   always_ff @(posedge clock) begin
      if (advance) begin
         olr_ff <= bypass ? bin_ff[NST-2].lr : pfin(glr_ff, lx);
         oli_ff <= bypass ? bin_ff[NST-2].li : pfin(gli_ff, lx);
         orr_ff <= bypass ? bin_ff[NST-2].rr : pfin(grr_ff, rx);
         ori_ff <= bypass ? bin_ff[NST-2].ri : pfin(gri_ff, rx);
      end
   end

   assign rsp_tdata = DW'({ori_ff, orr_ff, oli_ff, olr_ff});
   assign rsp_tlast = bin_ff[NST-1].last;

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow output stall");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[0])
      else $error("accepted transfer lost at pipe entry");
`endif

endmodule
